// File: hdl/sorted_key_table_core_defines.svh
// Assertion macros for the sorted key table checker.
// No dependencies; included by the checker file.
`ifndef SORTED_KEY_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/skt_pkg.sv
// Shared types and constants for the sorted key table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int KEY_W         = 48;
  localparam int PAY_W         = 32;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int INDEX_W       = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_DUP       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CMP    = 2'd1,
    ST_COMMIT = 2'd2
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_UPDATE = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } cell_data_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             cmp;
    cell_op_e         op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } cell_ctrl_t;

  // Registered compare results of one cell.
  typedef struct packed {
    logic match;  // holds the search key
    logic gt;     // empty or larger than the search key
    logic ge;     // empty or not smaller than the search key
  } cell_flags_t;

endpackage

`default_nettype wire

// File: hdl/skt_cell.sv
// One slot of the sorted key table: key, payload and compare flags.
// Depends on skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  skt_pkg::cell_ctrl_t  ctrl_i,
  input  skt_pkg::cell_data_t  lower_i,     // neighbor at slot - 1
  input  logic                 lower_gt_i,  // neighbor's gt flag
  input  skt_pkg::cell_data_t  upper_i,     // neighbor at slot + 1
  output skt_pkg::cell_data_t  data_o,
  output skt_pkg::cell_flags_t flags_o
);
  import skt_pkg::*;

  cell_data_t  data_q, data_d;
  cell_flags_t flags_q, flags_d;

  always_comb begin
    flags_d = flags_q;
    if (ctrl_i.cmp) begin
      flags_d.match = (data_q.key != '0) && (data_q.key == ctrl_i.key);
      flags_d.gt    = (data_q.key == '0) || (ctrl_i.key < data_q.key);
      flags_d.ge    = (data_q.key == '0) || (ctrl_i.key <= data_q.key);
    end
  end

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        // shift up above the insert point, take the new entry at it
        if (lower_gt_i) begin
          data_d = lower_i;
        end else if (flags_q.gt) begin
          data_d.key     = ctrl_i.key;
          data_d.payload = ctrl_i.payload;
        end
      end
      CELL_UPDATE: begin
        if (flags_q.match) begin
          data_d.payload = ctrl_i.payload;
        end
      end
      CELL_DELETE: begin
        // at and above the removed slot, pull down from the neighbor
        if (flags_q.ge) begin
          data_d = upper_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q  <= '0;
      flags_q <= '0;
    end else begin
      data_q  <= data_d;
      flags_q <= flags_d;
    end
  end

  assign data_o  = data_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

// File: hdl/sorted_key_table_core.sv
// Sorted key table: a row of slot cells kept in ascending key order.
// The result strobe done_o is registered and rises after the CMP and COMMIT states.
// A new transaction is taken only in IDLE; busy is high for the compare
// and commit states, set by the compare-then-shift sequence of the cells.
// Reset: asynchronous, active low; every slot empty, no result pending.
// The receiver cannot stall: done_o is high for one cycle only per result.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [skt_pkg::CMD_W-1:0]     command_i,
  input  logic [skt_pkg::KEY_W-1:0]     key_i,
  input  logic [skt_pkg::PAY_W-1:0]     payload_i,
  output logic                          done_o,
  output logic [skt_pkg::STATUS_W-1:0]  status_o,
  output logic [skt_pkg::INDEX_W-1:0]   index_o,
  output logic [skt_pkg::PAY_W-1:0]     payload_out_o
);
  import skt_pkg::*;

  // Sequencer: IDLE accepts, CMP lets every cell compare against the key,
  // COMMIT resolves the flags and tells the cells to shift or write.
  state_e state_q, state_d;

  // Captured transaction
  cmd_e             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] pay_q;

  // Result register
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [INDEX_W-1:0]  index_q, index_d;
  logic [PAY_W-1:0]    pout_q, pout_d;

  // Cell row
  cell_ctrl_t  ctrl;
  cell_data_t  cell_data  [TABLE_ENTRIES];
  cell_flags_t cell_flags [TABLE_ENTRIES];
  cell_data_t  lower_data [TABLE_ENTRIES];
  cell_data_t  upper_data [TABLE_ENTRIES];
  logic        lower_gt   [TABLE_ENTRIES];

  // Reductions over the row (at most one match and one insert point)
  logic              found;
  logic [SLOT_W-1:0] hit_slot;
  logic [PAY_W-1:0]  hit_pay;
  logic [SLOT_W-1:0] ins_slot;
  logic              full;

  logic [SLOT_W+INDEX_W-1:0] hit_ext, ins_ext;

  logic accept;
  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(command_i);
      key_q <= key_i;
      pay_q <= payload_i;
    end
  end

  // Neighbor wiring; the ends see empty slots.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cells
    if (g == 0) begin : g_first
      assign lower_data[g] = '0;
      assign lower_gt[g]   = 1'b0;
    end else begin : g_mid_lo
      assign lower_data[g] = cell_data[g-1];
      assign lower_gt[g]   = cell_flags[g-1].gt;
    end
    if (g == TABLE_ENTRIES - 1) begin : g_last
      assign upper_data[g] = '0;
    end else begin : g_mid_hi
      assign upper_data[g] = cell_data[g+1];
    end

    skt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .lower_i    (lower_data[g]),
      .lower_gt_i (lower_gt[g]),
      .upper_i    (upper_data[g]),
      .data_o     (cell_data[g]),
      .flags_o    (cell_flags[g])
    );
  end

  // One-hot AND-OR selection over the registered flags.
  always_comb begin
    found    = 1'b0;
    hit_slot = '0;
    hit_pay  = '0;
    ins_slot = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cell_flags[i].match) begin
        found    = 1'b1;
        hit_slot = hit_slot | SLOT_W'(i);
        hit_pay  = hit_pay | cell_data[i].payload;
      end
      if (cell_flags[i].gt && !lower_gt[i]) begin
        ins_slot = ins_slot | SLOT_W'(i);
      end
    end
  end

  // Empty slots sit at the end, so the table is full when the last is used.
  assign full    = (cell_data[TABLE_ENTRIES-1].key != '0);
  assign hit_ext = {{INDEX_W{1'b0}}, hit_slot};
  assign ins_ext = {{INDEX_W{1'b0}}, ins_slot};

  always_comb begin
    state_d      = state_q;
    done_d       = 1'b0;
    status_d     = status_q;
    index_d      = index_q;
    pout_d       = pout_q;
    ctrl.cmp     = 1'b0;
    ctrl.op      = CELL_HOLD;
    ctrl.key     = key_q;
    ctrl.payload = pay_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ctrl.cmp = 1'b1;
        state_d  = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_d  = ST_IDLE;
        done_d   = 1'b1;
        status_d = STATUS_OK;
        index_d  = '0;
        pout_d   = '0;
        if (cmd_q == CMD_INSERT) begin
          if (full) begin
            status_d = STATUS_FULL;
          end else if ((key_q == '0) || found) begin
            // key zero always counts as present
            status_d = STATUS_DUP;
          end else begin
            ctrl.op = CELL_INSERT;
            index_d = ins_ext[INDEX_W-1:0];
          end
        end else if (!found) begin
          status_d = STATUS_NOT_FOUND;
        end else begin
          index_d = hit_ext[INDEX_W-1:0];
          case (cmd_q)
            CMD_LOOKUP: pout_d  = hit_pay;
            CMD_UPDATE: ctrl.op = CELL_UPDATE;
            CMD_DELETE: ctrl.op = CELL_DELETE;
            default:    ctrl.op = CELL_HOLD;
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    index_q  <= index_d;
    pout_q   <= pout_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign index_o       = index_q;
  assign payload_out_o = pout_q;

endmodule

`default_nettype wire

// File: hdl/skt_checker.sv
// Port-level checks for sorted_key_table_core, bound to the top level.
// Depends on skt_pkg and sorted_key_table_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_table_core_defines.svh"

module skt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [skt_pkg::STATUS_W-1:0]  status_o,
  input logic [skt_pkg::INDEX_W-1:0]   index_o,
  input logic [skt_pkg::PAY_W-1:0]     payload_out_o
);
  import skt_pkg::*;

  `SKT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `SKT_ASSERT_NEXT(a_accept_done, start && !busy, ##2 done_o, "no result two cycles after accept")
  `SKT_ASSERT_NOW(a_done_idle, done_o, !busy, "result shown while busy")
  `SKT_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")
  `SKT_ASSERT_NOW(a_fail_zero, done_o && (status_o != STATUS_OK), (index_o == '0) && (payload_out_o == '0), "failed result carries data")

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .index_o       (index_o),
  .payload_out_o (payload_out_o)
);

`default_nettype wire

// File: tb/sorted_key_table_core_test.sv
// Self-checking testbench for sorted_key_table_core: insert, lookup, update and delete
// commands checked against a shadow copy of the sorted table. Depends on skt_pkg and
// the core RTL only.
`timescale 1ns / 1ps

module sorted_key_table_core_test;
  import skt_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int          BATCH_ITEMS    = 100;
  localparam int          NUM_BATCHES    = 7;
  localparam int          RECENT_MAX     = 32;
  localparam logic [KEY_W-1:0] KEY_MAX   = {KEY_W{1'b1}};

  typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_e;

  typedef struct {
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } table_cmd_t;

  typedef struct {
    status_e            status;
    logic [INDEX_W-1:0] index;
    logic [PAY_W-1:0]   payload_out;
  } table_reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    command_i;
  logic [KEY_W-1:0]    key_i;
  logic [PAY_W-1:0]    payload_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [INDEX_W-1:0]  index_o;
  logic [PAY_W-1:0]    payload_out_o;

  // Shadow of the table contents, kept in step with every accepted command.
  logic [KEY_W-1:0]    shadow_keys [TABLE_ENTRIES];
  logic [PAY_W-1:0]    shadow_pays [TABLE_ENTRIES];

  table_cmd_t          commands_queued[$];   // waiting for the driver
  table_reply_t        replies_due[$];       // predicted, not yet seen on done_o
  logic [KEY_W-1:0]    recent_keys[$];       // keys fed back so lookups/deletes hit

  bit                  cmd_held;             // start is up with an item not yet taken
  int                  idle_pct;             // sender idle chance per cycle, percent
  int                  error_count;
  int                  quiet_cycles;

  sorted_key_table_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .key_i        (key_i),
    .payload_i    (payload_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .index_o      (index_o),
    .payload_out_o(payload_out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow table step: applies one command and returns the reply it must produce.
  task automatic apply_to_shadow_table(input table_cmd_t c, output table_reply_t r);
    int  hit;
    int  pos;
    bit  has_empty;
    bit  placed;
    r   = '{status: STATUS_OK, index: '0, payload_out: '0};
    hit = TABLE_ENTRIES;
    // Key zero never matches, even though empty slots hold zero.
    if (c.key != '0) begin
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
        if (shadow_keys[i] == c.key) hit = i;
      end
    end
    if (c.cmd == CMD_INSERT) begin
      has_empty = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (shadow_keys[i] == '0) has_empty = 1'b1;
      end
      // Full takes precedence over duplicate; key zero counts as a duplicate.
      if (!has_empty) begin
        r.status = STATUS_FULL;
      end else if (c.key == '0 || hit < TABLE_ENTRIES) begin
        r.status = STATUS_DUP;
      end else begin
        pos    = TABLE_ENTRIES - 1;
        placed = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!placed && (shadow_keys[i] == '0 || c.key < shadow_keys[i])) begin
            pos    = i;
            placed = 1'b1;
          end
        end
        for (int i = TABLE_ENTRIES - 1; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_pays[i] = shadow_pays[i-1];
        end
        shadow_keys[pos] = c.key;
        shadow_pays[pos] = c.payload;
        r.index = pos[INDEX_W-1:0];
      end
    end else if (hit >= TABLE_ENTRIES) begin
      r.status = STATUS_NOT_FOUND;
    end else begin
      r.index = hit[INDEX_W-1:0];
      case (c.cmd)
        CMD_LOOKUP: begin
          r.payload_out = shadow_pays[hit];
        end
        CMD_UPDATE: begin
          shadow_pays[hit] = c.payload;
        end
        default: begin
          // Delete: close the gap, last slot becomes empty.
          for (int i = hit; i < TABLE_ENTRIES - 1; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_pays[i] = shadow_pays[i+1];
          end
          shadow_keys[TABLE_ENTRIES-1] = '0;
          shadow_pays[TABLE_ENTRIES-1] = '0;
        end
      endcase
    end
  endtask

  // Driver: inputs move on the falling edge. An item stays on the pins, start high,
  // until the monitor sees it taken; then the next one may follow back to back.
  always @(negedge clk_i) begin
    table_cmd_t nxt;
    if (rst_ni && !cmd_held) begin
      if (commands_queued.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt        = commands_queued.pop_front();
        start     <= 1'b1;
        command_i <= nxt.cmd;
        key_i     <= nxt.key;
        payload_i <= nxt.payload;
        cmd_held   = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: everything sampled at the rising edge. A result strobe in the same
  // cycle as an accept belongs to an older transaction, so it is checked first.
  // An expected result or an accept counts as progress for the watchdog.
  always @(posedge clk_i) begin
    table_reply_t want;
    table_cmd_t   taken;
    if (rst_ni) begin
      quiet_cycles++;
      if (done_o) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with none expected: status %0d index %0d payload %h",
                   $time, status_o, index_o, payload_out_o);
          error_count++;
        end else begin
          quiet_cycles = 0;
          want = replies_due.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            error_count++;
          end
          if (index_o !== want.index) begin
            $display("%0t: index expected %0d actual %0d", $time, want.index, index_o);
            error_count++;
          end
          if (payload_out_o !== want.payload_out) begin
            $display("%0t: payload_out expected %h actual %h",
                     $time, want.payload_out, payload_out_o);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        taken.cmd     = cmd_e'(command_i);
        taken.key     = key_i;
        taken.payload = payload_i;
        apply_to_shadow_table(taken, want);
        replies_due.push_back(want);
        cmd_held = 1'b0;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("sorted_key_table_core_test: done, errors");
        $finish;
      end
    end
  end

  task automatic queue_cmd(input cmd_e cmd, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] payload);
    commands_queued.push_back('{cmd: cmd, key: key, payload: payload});
  endtask

  // Random command; keys lean on ones already issued so that hits, duplicates
  // and deletes of live entries are common.
  task automatic queue_random_cmd(input mix_e mix);
    int               r;
    int               kr;
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  cmd = r < 80 ? CMD_INSERT : r < 88 ? CMD_LOOKUP :
                       r < 94 ? CMD_UPDATE : CMD_DELETE;
      MIX_DRAIN: cmd = r < 35 ? CMD_INSERT : r < 50 ? CMD_LOOKUP :
                       r < 60 ? CMD_UPDATE : CMD_DELETE;
      default:   cmd = cmd_e'(r % 4);
    endcase
    kr = $urandom_range(99);
    if (kr < 4) begin
      key = '0;
    end else if (kr < 8) begin
      key = $urandom_range(1) ? KEY_MAX : KEY_W'(1);
    end else if (kr < 20) begin
      key = KEY_W'($urandom_range(40, 1));
    end else if (kr < 60 && recent_keys.size() != 0) begin
      key = recent_keys[$urandom_range(recent_keys.size() - 1)];
    end else begin
      key = {16'($urandom), 32'($urandom)};
    end
    if (cmd == CMD_INSERT && key != '0) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > RECENT_MAX) void'(recent_keys.pop_front());
    end
    case ($urandom_range(19))
      0:       pay = '0;
      1:       pay = '1;
      default: pay = $urandom;
    endcase
    queue_cmd(cmd, key, pay);
  endtask

  // Sender holds off until the queue is empty and every reply has come back.
  task automatic wait_until_drained();
    while (commands_queued.size() != 0 || cmd_held || replies_due.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    mix_e batch_mix [NUM_BATCHES] = '{MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_EVEN,
                                      MIX_FILL, MIX_EVEN, MIX_DRAIN};
    int   batch_idle[NUM_BATCHES] = '{0, 56, 0, 26, 56, 0, 26};

    rst_ni       = 1'b0;
    start        = 1'b0;
    command_i    = CMD_LOOKUP;
    key_i        = '0;
    payload_i    = '0;
    cmd_held     = 1'b0;
    idle_pct     = 0;
    error_count  = 0;
    quiet_cycles = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_keys[i] = '0;
      shadow_pays[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table misses, key zero on every command, extreme keys and
    // payloads, a duplicate, then fill to full and try inserts past it.
    queue_cmd(CMD_LOOKUP, '0, '0);
    queue_cmd(CMD_DELETE, KEY_W'(7), '0);
    queue_cmd(CMD_UPDATE, KEY_W'(7), '1);
    queue_cmd(CMD_INSERT, '0, '1);
    queue_cmd(CMD_INSERT, KEY_MAX, '1);
    queue_cmd(CMD_INSERT, KEY_W'(1), '0);
    queue_cmd(CMD_INSERT, KEY_W'(1), 32'h1234_5678);
    queue_cmd(CMD_LOOKUP, KEY_MAX, '0);
    queue_cmd(CMD_UPDATE, KEY_W'(1), 32'hA5A5_A5A5);
    queue_cmd(CMD_DELETE, '0, '0);
    queue_cmd(CMD_UPDATE, '0, '0);
    for (int i = 2; i < TABLE_ENTRIES; i++)
      queue_cmd(CMD_INSERT, {4'(i), 40'h0, 4'(i)}, {8{4'(i)}});
    queue_cmd(CMD_INSERT, KEY_W'(16), '0);      // full
    queue_cmd(CMD_INSERT, '0, '0);              // full beats key zero
    queue_cmd(CMD_DELETE, KEY_MAX, '0);         // removes the last slot
    wait_until_drained();

    for (int b = 0; b < NUM_BATCHES; b++) begin
      idle_pct = batch_idle[b];
      for (int n = 0; n < BATCH_ITEMS; n++) queue_random_cmd(batch_mix[b]);
      wait_until_drained();
    end

    // Tail: wait on past the last result to catch stray strobes.
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sorted_key_table_core_test: done, clean");
    end else begin
      $display("sorted_key_table_core_test: done, errors");
    end
    $finish;
  end

endmodule
